[sv/mdp_pkg.sv]
// Shared types and constants for the microcoded datapath step block.
// Holds the microinstruction and result word layouts, B source codes and reset values.
// No dependencies.
package mdp_pkg;

  // B bus source codes; codes above the last one are rejected.
  localparam logic [3:0] BSEL_MDR  = 4'd0;
  localparam logic [3:0] BSEL_PC   = 4'd1;
  localparam logic [3:0] BSEL_MBR  = 4'd2;
  localparam logic [3:0] BSEL_MBRU = 4'd3;
  localparam logic [3:0] BSEL_SP   = 4'd4;
  localparam logic [3:0] BSEL_LV   = 4'd5;
  localparam logic [3:0] BSEL_CPP  = 4'd6;
  localparam logic [3:0] BSEL_TOS  = 4'd7;
  localparam logic [3:0] BSEL_OPC  = 4'd8;

  // ALU function codes as {func0, func1}.
  localparam logic [1:0] FN_AND  = 2'b00;
  localparam logic [1:0] FN_OR   = 2'b01;
  localparam logic [1:0] FN_NOTB = 2'b10;
  localparam logic [1:0] FN_ADD  = 2'b11;

  // C bus enable bit positions.
  localparam int unsigned CEN_H   = 8;
  localparam int unsigned CEN_OPC = 7;
  localparam int unsigned CEN_TOS = 6;
  localparam int unsigned CEN_CPP = 5;
  localparam int unsigned CEN_LV  = 4;
  localparam int unsigned CEN_SP  = 3;
  localparam int unsigned CEN_PC  = 2;
  localparam int unsigned CEN_MDR = 1;
  localparam int unsigned CEN_MAR = 0;

  // Register reset values.
  localparam logic [31:0] RST_H   = 32'd0;
  localparam logic [31:0] RST_OPC = 32'd0;
  localparam logic [31:0] RST_TOS = 32'd8;
  localparam logic [31:0] RST_CPP = 32'd0;
  localparam logic [31:0] RST_LV  = 32'd1;
  localparam logic [31:0] RST_SP  = 32'd4;
  localparam logic [31:0] RST_PC  = 32'd0;
  localparam logic [31:0] RST_MDR = 32'd0;
  localparam logic [31:0] RST_MAR = 32'd4;
  localparam logic [7:0]  RST_MBR = 8'd0;

  localparam logic [31:0] SIGN_BIT  = 32'h8000_0000;
  localparam logic [31:0] WORD_MASK = 32'hFFFF_FFFF;

  typedef struct packed {
    logic       shift_left8;
    logic       shift_right1;
    logic       func0;
    logic       func1;
    logic       enable_a;
    logic       enable_b;
    logic       invert_a;
    logic       increment;
    logic [8:0] c_enables;
    logic       mem_write;
    logic       mem_read;
    logic [3:0] b_select;
  } mdp_uop_t;

  typedef struct packed {
    logic [31:0]        alu_sum;
    logic [31:0]        shifter_out;
    logic               carry_out;
    logic               negative_flag;
    logic               zero_flag;
    logic               shift_conflict;
    logic               memory_conflict;
    logic               bad_b_select;
    logic               memory_ignored;
    logic signed [31:0] mar_value;
    logic signed [31:0] mdr_value;
    logic signed [31:0] h_value;
  } mdp_result_t;

  // ALU and shifter controls taken from the microinstruction.
  typedef struct packed {
    logic shift_left8;
    logic shift_right1;
    logic func0;
    logic func1;
    logic enable_a;
    logic enable_b;
    logic invert_a;
    logic increment;
  } mdp_alu_ctrl_t;

  typedef struct packed {
    logic [31:0] sum;
    logic [31:0] shifted;
    logic        carry;
    logic        shift_conflict;
  } mdp_alu_res_t;

endpackage

[sv/mdp_if.sv]
// Handshake channels of the microcoded datapath step block.
// Microinstruction, result and configuration channels; uses mdp_pkg.
interface mdp_uop_if;
  logic             valid;
  logic             ready;
  mdp_pkg::mdp_uop_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mdp_res_if;
  logic                valid;
  logic                ready;
  mdp_pkg::mdp_result_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mdp_cfg_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] mbr_byte;
  modport source (output valid, output mbr_byte, input ready);
  modport sink   (input valid, input mbr_byte, output ready);
endinterface

[sv/mdp_alu.sv]
// ALU and shifter of the microcoded datapath step block.
// Forms AND, OR, NOT B or A+B, adds the increment, then SLL8 or SRA1; uses mdp_pkg.
module mdp_alu (
  input  mdp_pkg::mdp_alu_ctrl_t ctrl,
  input  logic [31:0]            a_src,
  input  logic [31:0]            b_src,
  output mdp_pkg::mdp_alu_res_t  res
);

  logic [31:0] a_op;
  logic [31:0] b_op;
  logic [31:0] logic_op;
  logic [31:0] add_op;
  logic [32:0] full_sum;

  // Gate and invert the operands
  always_comb begin
    a_op = ctrl.enable_a ? a_src : '0;
    if (ctrl.invert_a) begin
      a_op = ~a_op;
    end
    b_op = ctrl.enable_b ? b_src : '0;
  end

  // Pick the function; one adder serves the sum and the increment
  always_comb begin
    add_op = '0;
    case ({ctrl.func0, ctrl.func1})
      mdp_pkg::FN_AND:  logic_op = a_op & b_op;
      mdp_pkg::FN_OR:   logic_op = a_op | b_op;
      mdp_pkg::FN_NOTB: logic_op = ~b_op;
      default: begin
        logic_op = a_op;
        add_op   = b_op;
      end
    endcase
    full_sum = {1'b0, logic_op} + {1'b0, add_op} + {32'd0, ctrl.increment};
  end

  // Shift the ALU output; both controls set leaves it unshifted
  always_comb begin
    res.sum            = full_sum[31:0];
    res.carry          = full_sum[32];
    res.shift_conflict = ctrl.shift_left8 & ctrl.shift_right1;
    res.shifted        = full_sum[31:0];
    if (!res.shift_conflict) begin
      if (ctrl.shift_left8) begin
        res.shifted = {full_sum[23:0], 8'd0};
      end else if (ctrl.shift_right1) begin
        res.shifted = {full_sum[31], full_sum[31:1]};
      end
    end
  end

endmodule

[sv/mdp_mem.sv]
// Data memory of the microcoded datapath step block.
// One write and one registered read per cycle on one shared address; per-word fill bits make unwritten words read zero.
module mdp_mem #(
  parameter int MEM_WORDS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         wr_en,
  input  logic                         rd_en,
  input  logic [$clog2(MEM_WORDS)-1:0] addr,
  input  logic [31:0]                  wdata,
  output logic [31:0]                  rdata
);

  logic [31:0]          ram [MEM_WORDS];
  logic [MEM_WORDS-1:0] filled;
  logic [31:0]          rd_word;
  logic                 rd_hit;

  // Write the array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[addr] <= wdata;
    end
  end

  // Mark written words; reset clears every mark at once
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (wr_en) begin
      filled[addr] <= 1'b1;
    end
  end

  // Register the read word and its fill mark
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_word <= ram[addr];
      rd_hit  <= filled[addr];
    end
  end

  assign rdata = rd_hit ? rd_word : '0;

endmodule

[sv/microcoded_datapath_step.sv]
// Top level of the microcoded datapath step block: input register, register file,
// B mux, C bus write-back and result register. Uses mdp_pkg, mdp_if, mdp_alu, mdp_mem.
//
//   channel  | dir | handshake           | word
//   uop_in   | in  | valid / ready       | mdp_uop_t microinstruction
//   res_out  | out | valid / ready       | mdp_result_t result, one per microinstruction
//   cfg      | in  | valid / ready (=1)  | mbr_byte, signed instruction byte
//
// One microinstruction per clock while the result is not stalled: while a word sits in the
// input register, ALU, shifter, write-back and memory access complete combinationally into
// the result register, which offers the result word. A memory read lands in the read
// register of the memory and is forwarded to the next word's MDR. Reset loads the register
// reset values and clears the memory fill marks and both valid flags.
// A stalled result holds the input register; the input side keeps accepting while the
// result is taken.
module microcoded_datapath_step #(
  parameter int MEM_WORDS = 8
) (
  input  logic       clk,
  input  logic       rst,
  mdp_cfg_if.sink    cfg,
  mdp_uop_if.sink    uop_in,
  mdp_res_if.source  res_out
);

  localparam int AW = $clog2(MEM_WORDS);

  // Input register
  mdp_pkg::mdp_uop_t uop_q;
  logic              uop_valid;
  logic              advance;

  // Architectural state
  logic [31:0] h_reg, opc_reg, tos_reg, cpp_reg, lv_reg, sp_reg, pc_reg, mdr_reg, mar_reg;
  logic [7:0]  mbr_byte;
  logic        mdr_from_mem;

  // Result register
  mdp_pkg::mdp_result_t res_q;
  mdp_pkg::mdp_result_t res_next;
  logic                 res_valid;
  logic                 res_mdr_mem;

  // Datapath
  logic                   bad_sel;
  logic [31:0]            mdr_eff;
  logic [31:0]            mem_rdata;
  logic [31:0]            b_src;
  logic [31:0]            cval;
  logic [8:0]             cen;
  logic [31:0]            mar_c;
  logic [31:0]            mdr_c;
  logic                   access;
  logic                   in_range;
  logic                   mem_we;
  logic                   mem_re;
  logic                   read_ok;
  mdp_pkg::mdp_alu_ctrl_t alu_ctrl;
  mdp_pkg::mdp_alu_res_t  alu_res;

  // Handshakes: advance when the result slot is free or being emptied
  assign advance      = uop_valid && (!res_valid || res_out.ready);
  assign uop_in.ready = !uop_valid || advance;
  assign cfg.ready    = 1'b1;

  // Hold the word in the input register until it advances
  always_ff @(posedge clk) begin
    if (rst) begin
      uop_valid <= 1'b0;
    end else if (uop_in.ready) begin
      uop_valid <= uop_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (uop_in.ready && uop_in.valid) begin
      uop_q <= uop_in.data;
    end
  end

  // Take the configuration byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mbr_byte <= mdp_pkg::RST_MBR;
    end else if (cfg.valid) begin
      mbr_byte <= cfg.mbr_byte;
    end
  end

  // MDR comes from the memory read register after a read
  assign mdr_eff = mdr_from_mem ? mem_rdata : mdr_reg;
  assign bad_sel = uop_q.b_select > mdp_pkg::BSEL_OPC;
  assign cen     = uop_q.c_enables;

  // Drive the B bus
  always_comb begin
    unique case (uop_q.b_select) inside
      mdp_pkg::BSEL_MDR:                    b_src = mdr_eff;
      mdp_pkg::BSEL_PC:                     b_src = pc_reg;
      mdp_pkg::BSEL_MBR, mdp_pkg::BSEL_MBRU: b_src = {{24{mbr_byte[7]}}, mbr_byte};
      mdp_pkg::BSEL_SP:                     b_src = sp_reg;
      mdp_pkg::BSEL_LV:                     b_src = lv_reg;
      mdp_pkg::BSEL_CPP:                    b_src = cpp_reg;
      mdp_pkg::BSEL_TOS:                    b_src = tos_reg;
      mdp_pkg::BSEL_OPC:                    b_src = opc_reg;
      default:                              b_src = '0;
    endcase
  end

  assign alu_ctrl = '{
    shift_left8:  uop_q.shift_left8,
    shift_right1: uop_q.shift_right1,
    func0:        uop_q.func0,
    func1:        uop_q.func1,
    enable_a:     uop_q.enable_a,
    enable_b:     uop_q.enable_b,
    invert_a:     uop_q.invert_a,
    increment:    uop_q.increment
  };

  mdp_alu u_alu (
    .ctrl  (alu_ctrl),
    .a_src (h_reg),
    .b_src (b_src),
    .res   (alu_res)
  );

  // C bus value; the unsigned byte select keeps only the low byte
  assign cval = (uop_q.b_select == mdp_pkg::BSEL_MBRU) ? {24'd0, alu_res.shifted[7:0]}
                                                       : alu_res.shifted;

  assign mar_c = (!bad_sel && cen[mdp_pkg::CEN_MAR]) ? cval : mar_reg;
  assign mdr_c = (!bad_sel && cen[mdp_pkg::CEN_MDR]) ? cval : mdr_eff;

  // Memory access after write-back, on the updated MAR and MDR
  assign access   = !bad_sel && (uop_q.mem_write ^ uop_q.mem_read);
  assign in_range = mar_c < 32'(MEM_WORDS);
  assign read_ok  = access && in_range && uop_q.mem_read;
  assign mem_we   = advance && access && in_range && uop_q.mem_write;
  assign mem_re   = advance && read_ok;

  mdp_mem #(
    .MEM_WORDS (MEM_WORDS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .wr_en (mem_we),
    .rd_en (mem_re),
    .addr  (mar_c[AW-1:0]),
    .wdata (mdr_c),
    .rdata (mem_rdata)
  );

  // Write back the enabled registers
  always_ff @(posedge clk) begin
    if (rst) begin
      h_reg        <= mdp_pkg::RST_H;
      opc_reg      <= mdp_pkg::RST_OPC;
      tos_reg      <= mdp_pkg::RST_TOS;
      cpp_reg      <= mdp_pkg::RST_CPP;
      lv_reg       <= mdp_pkg::RST_LV;
      sp_reg       <= mdp_pkg::RST_SP;
      pc_reg       <= mdp_pkg::RST_PC;
      mdr_reg      <= mdp_pkg::RST_MDR;
      mar_reg      <= mdp_pkg::RST_MAR;
      mdr_from_mem <= 1'b0;
    end else if (advance) begin
      if (!bad_sel && cen[mdp_pkg::CEN_H])   h_reg   <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_OPC]) opc_reg <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_TOS]) tos_reg <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_CPP]) cpp_reg <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_LV])  lv_reg  <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_SP])  sp_reg  <= cval;
      if (!bad_sel && cen[mdp_pkg::CEN_PC])  pc_reg  <= cval;
      mdr_reg      <= mdr_c;
      mar_reg      <= mar_c;
      mdr_from_mem <= read_ok;
    end
  end

  // Assemble the result word
  always_comb begin
    res_next.alu_sum         = bad_sel ? '0 : alu_res.sum;
    res_next.shifter_out     = bad_sel ? '0 : alu_res.shifted;
    res_next.carry_out       = !bad_sel && alu_res.carry;
    res_next.negative_flag   = !bad_sel && alu_res.shifted[31];
    res_next.zero_flag       = !bad_sel && (alu_res.shifted == '0);
    res_next.shift_conflict  = !bad_sel && alu_res.shift_conflict;
    res_next.memory_conflict = !bad_sel && uop_q.mem_write && uop_q.mem_read;
    res_next.bad_b_select    = bad_sel;
    res_next.memory_ignored  = access && !in_range;
    res_next.mar_value       = mar_c;
    res_next.mdr_value       = mdr_c;
    res_next.h_value         = (!bad_sel && cen[mdp_pkg::CEN_H]) ? cval : h_reg;
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q       <= res_next;
      res_mdr_mem <= read_ok;
    end
  end

  // A read result stays in the memory read register until the next read
  always_comb begin
    res_out.data = res_q;
    if (res_mdr_mem) begin
      res_out.data.mdr_value = mem_rdata;
    end
  end
  assign res_out.valid = res_valid;

`ifndef SYNTHESIS
  // A rejected B select leaves the registers untouched
  assert property (@(posedge clk) disable iff (rst)
    (advance && bad_sel) |=> (h_reg == $past(h_reg) && mar_reg == $past(mar_reg)
                              && pc_reg == $past(pc_reg) && !mdr_from_mem))
    else $error("bad B select changed state");

  // A word that advances always shows up as a result
  assert property (@(posedge clk) disable iff (rst)
    advance |=> res_valid)
    else $error("advanced word produced no result");

  // The two memory flags exclude each other
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_q.memory_conflict && res_q.memory_ignored))
    else $error("memory conflict and ignore both flagged");

  // MDR forwarding only starts from a read that advanced
  assert property (@(posedge clk) disable iff (rst)
    $rose(mdr_from_mem) |-> $past(mem_re))
    else $error("MDR forwarding without a memory read");

  // No memory write while the result slot is stalled
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_out.ready) |-> !mem_we)
    else $error("memory written under stall");
`endif

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for microcoded_datapath_step: directed table, then random micro-op phases.
// Predicts untyped result words from a local register file and memory copy; uses mdp_pkg, mdp_if.
module tb_top;

  localparam int MEM_WORDS = 8;
  localparam int IDLE_LIMIT = 2000;
  localparam int PHASE_WORDS = 126;

  // ALU function codes as {func0, func1}
  localparam logic [1:0] FN_AND  = mdp_pkg::FN_AND;
  localparam logic [1:0] FN_OR   = mdp_pkg::FN_OR;
  localparam logic [1:0] FN_NOTB = mdp_pkg::FN_NOTB;
  localparam logic [1:0] FN_ADD  = mdp_pkg::FN_ADD;

  // C bus enable masks
  localparam logic [8:0] EN_H   = 9'(1 << mdp_pkg::CEN_H);
  localparam logic [8:0] EN_OPC = 9'(1 << mdp_pkg::CEN_OPC);
  localparam logic [8:0] EN_TOS = 9'(1 << mdp_pkg::CEN_TOS);
  localparam logic [8:0] EN_CPP = 9'(1 << mdp_pkg::CEN_CPP);
  localparam logic [8:0] EN_LV  = 9'(1 << mdp_pkg::CEN_LV);
  localparam logic [8:0] EN_SP  = 9'(1 << mdp_pkg::CEN_SP);
  localparam logic [8:0] EN_PC  = 9'(1 << mdp_pkg::CEN_PC);
  localparam logic [8:0] EN_MDR = 9'(1 << mdp_pkg::CEN_MDR);
  localparam logic [8:0] EN_MAR = 9'(1 << mdp_pkg::CEN_MAR);

  typedef struct {
    bit                   typed;
    mdp_pkg::mdp_result_t want;
  } pending_t;

  typedef struct {
    bit                   set_mbr;
    logic signed [7:0]    mbr;
    mdp_pkg::mdp_uop_t    word;
    bit                   typed;
    mdp_pkg::mdp_result_t want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  bit   calm;
  int   mismatches;
  int   words_sent;
  int   idle_cycles;

  // Predicted datapath state, indexed by C bus bit position
  logic [31:0]       rf [9];
  logic [31:0]       mem_model [MEM_WORDS];
  logic signed [7:0] mbr_now;

  pending_t             pend_q [$];
  mdp_pkg::mdp_result_t want_q [$];
  dir_row_t             plan [25];

  mdp_cfg_if cfg_ch ();
  mdp_uop_if uop_ch ();
  mdp_res_if res_ch ();

  microcoded_datapath_step #(.MEM_WORDS(MEM_WORDS)) DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .uop_in  (uop_ch),
    .res_out (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic mdp_pkg::mdp_uop_t microword(input logic sll, input logic sra,
                                                  input logic [1:0] fn, input logic ena,
                                                  input logic enb, input logic inva,
                                                  input logic inc, input logic [8:0] cen,
                                                  input logic wr, input logic rd,
                                                  input logic [3:0] sel);
    mdp_pkg::mdp_uop_t u;
    u.shift_left8  = sll;
    u.shift_right1 = sra;
    u.func0        = fn[1];
    u.func1        = fn[0];
    u.enable_a     = ena;
    u.enable_b     = enb;
    u.invert_a     = inva;
    u.increment    = inc;
    u.c_enables    = cen;
    u.mem_write    = wr;
    u.mem_read     = rd;
    u.b_select     = sel;
    return u;
  endfunction

  function automatic mdp_pkg::mdp_result_t outcome(input logic [31:0] alu,
                                                   input logic [31:0] sh,
                                                   input logic c, input logic n, input logic z,
                                                   input logic sc, input logic mc,
                                                   input logic bad, input logic ign,
                                                   input logic [31:0] mar,
                                                   input logic [31:0] mdr,
                                                   input logic [31:0] h);
    mdp_pkg::mdp_result_t r;
    r.alu_sum         = alu;
    r.shifter_out     = sh;
    r.carry_out       = c;
    r.negative_flag   = n;
    r.zero_flag       = z;
    r.shift_conflict  = sc;
    r.memory_conflict = mc;
    r.bad_b_select    = bad;
    r.memory_ignored  = ign;
    r.mar_value       = mar;
    r.mdr_value       = mdr;
    r.h_value         = h;
    return r;
  endfunction

  // Execute one microinstruction on the predicted state and return its result word
  function automatic mdp_pkg::mdp_result_t execute_word(input mdp_pkg::mdp_uop_t u);
    mdp_pkg::mdp_result_t r;
    logic [31:0] a, b, sh, cval;
    logic [32:0] sum;
    r = '0;
    if (u.b_select > mdp_pkg::BSEL_OPC) begin
      r.bad_b_select = 1'b1;
    end else begin
      a = u.enable_a ? rf[mdp_pkg::CEN_H] : 32'd0;
      if (u.invert_a) a = ~a;
      case (u.b_select)
        mdp_pkg::BSEL_MDR:                     b = rf[mdp_pkg::CEN_MDR];
        mdp_pkg::BSEL_PC:                      b = rf[mdp_pkg::CEN_PC];
        mdp_pkg::BSEL_MBR, mdp_pkg::BSEL_MBRU: b = {{24{mbr_now[7]}}, mbr_now};
        mdp_pkg::BSEL_SP:                      b = rf[mdp_pkg::CEN_SP];
        mdp_pkg::BSEL_LV:                      b = rf[mdp_pkg::CEN_LV];
        mdp_pkg::BSEL_CPP:                     b = rf[mdp_pkg::CEN_CPP];
        mdp_pkg::BSEL_TOS:                     b = rf[mdp_pkg::CEN_TOS];
        default:                               b = rf[mdp_pkg::CEN_OPC];
      endcase
      if (!u.enable_b) b = 32'd0;
      case ({u.func0, u.func1})
        FN_ADD:  sum = {1'b0, a} + {1'b0, b} + 33'(u.increment);
        FN_NOTB: sum = {1'b0, ~b} + 33'(u.increment);
        FN_OR:   sum = {1'b0, a | b} + 33'(u.increment);
        default: sum = {1'b0, a & b} + 33'(u.increment);
      endcase
      r.alu_sum   = sum[31:0];
      r.carry_out = sum[32];
      // both shifts together leave the word unshifted
      sh = sum[31:0];
      r.shift_conflict = u.shift_left8 && u.shift_right1;
      if (!r.shift_conflict) begin
        if (u.shift_left8) sh = sh << 8;
        else if (u.shift_right1) sh = {sh[31], sh[31:1]};
      end
      r.shifter_out   = sh;
      r.negative_flag = sh[31];
      r.zero_flag     = (sh == 32'd0);
      // MBRU writes back only the zero-extended low byte
      cval = (u.b_select == mdp_pkg::BSEL_MBRU) ? {24'd0, sh[7:0]} : sh;
      for (int i = 0; i < 9; i++) begin
        if (u.c_enables[i]) rf[i] = cval;
      end
      // memory access with the updated MAR and MDR
      if (u.mem_write && u.mem_read) begin
        r.memory_conflict = 1'b1;
      end else if (u.mem_write || u.mem_read) begin
        if (rf[mdp_pkg::CEN_MAR] < MEM_WORDS) begin
          if (u.mem_read) rf[mdp_pkg::CEN_MDR] = mem_model[rf[mdp_pkg::CEN_MAR]];
          else mem_model[rf[mdp_pkg::CEN_MAR]] = rf[mdp_pkg::CEN_MDR];
        end else begin
          r.memory_ignored = 1'b1;
        end
      end
    end
    r.mar_value = rf[mdp_pkg::CEN_MAR];
    r.mdr_value = rf[mdp_pkg::CEN_MDR];
    r.h_value   = rf[mdp_pkg::CEN_H];
    return r;
  endfunction

  task automatic field_check(input string tag, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", tag, want, got);
    end
  endtask

  task automatic check_result(input mdp_pkg::mdp_result_t want,
                              input mdp_pkg::mdp_result_t got);
    field_check("alu_sum", want.alu_sum, got.alu_sum);
    field_check("shifter_out", want.shifter_out, got.shifter_out);
    field_check("carry_out", 32'(want.carry_out), 32'(got.carry_out));
    field_check("negative_flag", 32'(want.negative_flag), 32'(got.negative_flag));
    field_check("zero_flag", 32'(want.zero_flag), 32'(got.zero_flag));
    field_check("shift_conflict", 32'(want.shift_conflict), 32'(got.shift_conflict));
    field_check("memory_conflict", 32'(want.memory_conflict), 32'(got.memory_conflict));
    field_check("bad_b_select", 32'(want.bad_b_select), 32'(got.bad_b_select));
    field_check("memory_ignored", 32'(want.memory_ignored), 32'(got.memory_ignored));
    field_check("mar_value", want.mar_value, got.mar_value);
    field_check("mdr_value", want.mdr_value, got.mdr_value);
    field_check("h_value", want.h_value, got.h_value);
  endtask

  function automatic mdp_pkg::mdp_uop_t random_word(input bit legal);
    logic [31:0] raw;
    mdp_pkg::mdp_uop_t u;
    raw = $urandom;
    u = raw[$bits(mdp_pkg::mdp_uop_t)-1:0];
    if (legal) u.b_select = 4'($urandom_range(mdp_pkg::BSEL_OPC));
    return u;
  endfunction

  // Mostly single accesses, a few idle or conflicting ones
  function automatic mdp_pkg::mdp_uop_t with_mem_op(input mdp_pkg::mdp_uop_t u);
    int pick;
    pick = $urandom_range(9);
    u.mem_read  = (pick <= 3) || (pick == 9);
    u.mem_write = (pick >= 4 && pick <= 7) || (pick == 9);
    return u;
  endfunction

  // Hand a word to the block, idling first at random; valid stays high afterwards
  task automatic send_word(input mdp_pkg::mdp_uop_t u, input bit typed,
                           input mdp_pkg::mdp_result_t want);
    pending_t entry;
    while (!calm && $urandom_range(99) < 7) begin
      uop_ch.valid <= 1'b0;
      @(posedge clk);
    end
    entry.typed = typed;
    entry.want  = want;
    pend_q.insert(pend_q.size(), entry);
    uop_ch.valid <= 1'b1;
    uop_ch.data  <= u;
    do @(posedge clk); while (!uop_ch.ready);
    words_sent++;
  endtask

  // Drain every outstanding word, then write the instruction byte
  task automatic write_mbr(input logic signed [7:0] value);
    uop_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_ch.valid    <= 1'b1;
    cfg_ch.mbr_byte <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Point H and MAR at a low address, then step them up with accesses and data words between
  task automatic run_walk();
    mdp_pkg::mdp_uop_t u;
    int steps;
    steps = $urandom_range(14, 3);
    u = microword(1'b0, 1'b0, FN_AND, 1'b0, 1'b0, 1'b0, 1'($urandom_range(1)),
                  {1'b1, 7'($urandom), 1'b1}, 1'b0, 1'b0, mdp_pkg::BSEL_MDR);
    send_word(with_mem_op(u), 1'b0, '0);
    repeat (steps) begin
      if ($urandom_range(2) == 0) begin
        u = random_word(1'b1);
        u.c_enables[mdp_pkg::CEN_H]   = 1'b0;
        u.c_enables[mdp_pkg::CEN_MAR] = 1'b0;
      end else begin
        u = microword(1'b0, 1'b0, FN_ADD, 1'b1, 1'b0, 1'b0, 1'b1,
                      {1'b1, 7'($urandom), 1'b1}, 1'b0, 1'b0, mdp_pkg::BSEL_MDR);
      end
      send_word(with_mem_op(u), 1'b0, '0);
    end
  endtask

  // Result sink: stall at random outside the calm phase
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res_ch.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  // Track handshakes: predict on accepted words, check result words, watch for a hang
  always @(posedge clk) begin : monitor
    pending_t             pend;
    mdp_pkg::mdp_result_t guess;
    bit                   moved;
    moved = 1'b0;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        mbr_now = cfg_ch.mbr_byte;
        moved = 1'b1;
      end
      if (uop_ch.valid && uop_ch.ready) begin
        pend  = pend_q.pop_front();
        guess = execute_word(uop_ch.data);
        want_q.insert(want_q.size(), pend.typed ? pend.want : guess);
        moved = 1'b1;
      end
      if (res_ch.valid && res_ch.ready) begin
        moved = 1'b1;
        if (want_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result word with nothing expected: %p", res_ch.data);
        end else begin
          check_result(want_q.pop_front(), res_ch.data);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic signed [7:0] phase_mbr [5];
    int phase_end;
    int pick;
    rst             <= 1'b1;
    uop_ch.valid    <= 1'b0;
    uop_ch.data     <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.mbr_byte <= '0;
    calm        = 1'b0;
    mismatches  = 0;
    words_sent  = 0;
    idle_cycles = 0;
    mbr_now     = mdp_pkg::RST_MBR;
    rf[mdp_pkg::CEN_H]   = mdp_pkg::RST_H;
    rf[mdp_pkg::CEN_OPC] = mdp_pkg::RST_OPC;
    rf[mdp_pkg::CEN_TOS] = mdp_pkg::RST_TOS;
    rf[mdp_pkg::CEN_CPP] = mdp_pkg::RST_CPP;
    rf[mdp_pkg::CEN_LV]  = mdp_pkg::RST_LV;
    rf[mdp_pkg::CEN_SP]  = mdp_pkg::RST_SP;
    rf[mdp_pkg::CEN_PC]  = mdp_pkg::RST_PC;
    rf[mdp_pkg::CEN_MDR] = mdp_pkg::RST_MDR;
    rf[mdp_pkg::CEN_MAR] = mdp_pkg::RST_MAR;
    foreach (mem_model[i]) mem_model[i] = 32'd0;

    // Directed words: the first ten start from reset and carry typed results
    plan = '{
      // no-op: zero result, reset registers visible
      '{0, 8'sd0, microword(0, 0, FN_AND, 0, 0, 0, 0, 9'h000, 0, 0, mdp_pkg::BSEL_MDR), 1,
        outcome(32'h0, 32'h0, 0, 0, 1, 0, 0, 0, 0, 32'd4, 32'd0, 32'd0)},
      // bad B select with every other field set: no effect
      '{0, 8'sd0, microword(1, 1, FN_ADD, 1, 1, 1, 1, 9'h1FF, 1, 1, 4'd15), 1,
        outcome(32'h0, 32'h0, 0, 0, 0, 0, 0, 1, 0, 32'd4, 32'd0, 32'd0)},
      '{0, 8'sd0, microword(0, 1, FN_OR, 1, 1, 0, 0, EN_H | EN_MAR, 0, 1, 4'd9), 1,
        outcome(32'h0, 32'h0, 0, 0, 0, 0, 0, 1, 0, 32'd4, 32'd0, 32'd0)},
      // NOT of zero into H
      '{0, 8'sd0, microword(0, 0, FN_NOTB, 0, 0, 0, 0, EN_H, 0, 0, mdp_pkg::BSEL_MDR), 1,
        outcome(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 0, 32'd4, 32'd0,
                32'hFFFF_FFFF)},
      // NOT of zero plus one wraps with carry
      '{0, 8'sd0, microword(0, 0, FN_NOTB, 0, 0, 0, 1, 9'h000, 0, 0, mdp_pkg::BSEL_MDR), 1,
        outcome(32'h0, 32'h0, 1, 0, 1, 0, 0, 0, 0, 32'd4, 32'd0, 32'hFFFF_FFFF)},
      // H plus one wraps, both shifts set
      '{0, 8'sd0, microword(1, 1, FN_ADD, 1, 0, 0, 1, EN_H, 0, 0, mdp_pkg::BSEL_MDR), 1,
        outcome(32'h0, 32'h0, 1, 0, 1, 1, 0, 0, 0, 32'd4, 32'd0, 32'd0)},
      // read and write together
      '{0, 8'sd0, microword(0, 0, FN_AND, 0, 0, 0, 0, 9'h000, 1, 1, mdp_pkg::BSEL_MDR), 1,
        outcome(32'h0, 32'h0, 0, 0, 1, 0, 1, 0, 0, 32'd4, 32'd0, 32'd0)},
      // read of a cleared word
      '{0, 8'sd0, microword(0, 0, FN_AND, 0, 0, 0, 0, 9'h000, 0, 1, mdp_pkg::BSEL_MDR), 1,
        outcome(32'h0, 32'h0, 0, 0, 1, 0, 0, 0, 0, 32'd4, 32'd0, 32'd0)},
      // negative MAR skips the write
      '{0, 8'sd0, microword(0, 0, FN_NOTB, 0, 0, 0, 0, EN_MAR, 1, 0, mdp_pkg::BSEL_MDR), 1,
        outcome(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0, 1, 32'hFFFF_FFFF, 32'd0,
                32'd0)},
      // MAR one past the top skips the read
      '{0, 8'sd0, microword(0, 0, FN_OR, 0, 1, 0, 0, EN_MAR, 0, 1, mdp_pkg::BSEL_TOS), 1,
        outcome(32'd8, 32'd8, 0, 0, 0, 0, 0, 0, 1, 32'd8, 32'd0, 32'd0)},
      // instruction byte extremes, signed and unsigned views
      '{1, -8'sd128, microword(0, 1, FN_OR, 0, 1, 0, 0, EN_H | EN_MDR, 0, 0,
                               mdp_pkg::BSEL_MBR), 0, '0},
      '{0, 8'sd0, microword(0, 0, FN_ADD, 1, 1, 0, 1, EN_H | EN_OPC | EN_MAR, 0, 1,
                            mdp_pkg::BSEL_MBRU), 0, '0},
      '{0, 8'sd0, microword(1, 0, FN_OR, 0, 1, 0, 0, 9'h1FF, 0, 0, mdp_pkg::BSEL_MBRU),
        0, '0},
      '{1, 8'sd127, microword(1, 0, FN_OR, 0, 1, 0, 0, EN_TOS | EN_CPP, 0, 0,
                              mdp_pkg::BSEL_MBR), 0, '0},
      // bottom and top of memory
      '{0, 8'sd0, microword(0, 0, FN_AND, 0, 0, 0, 0, EN_H | EN_MAR, 1, 0, mdp_pkg::BSEL_MDR),
        0, '0},
      '{0, 8'sd0, microword(0, 0, FN_ADD, 1, 0, 0, 1, EN_H | EN_MAR | EN_MDR, 1, 0,
                            mdp_pkg::BSEL_MDR), 0, '0},
      '{1, 8'sd7, microword(0, 0, FN_OR, 0, 1, 0, 0, EN_MAR | EN_LV, 1, 0,
                            mdp_pkg::BSEL_MBRU), 0, '0},
      '{0, 8'sd0, microword(0, 0, FN_NOTB, 0, 0, 0, 0, EN_MDR, 0, 1, mdp_pkg::BSEL_MDR),
        0, '0},
      // remaining B sources
      '{0, 8'sd0, microword(0, 1, FN_ADD, 1, 1, 1, 0, EN_PC | EN_SP | EN_CPP, 0, 0,
                            mdp_pkg::BSEL_PC), 0, '0},
      '{0, 8'sd0, microword(0, 0, FN_OR, 1, 1, 0, 0, EN_OPC | EN_SP, 0, 0, mdp_pkg::BSEL_SP),
        0, '0},
      '{0, 8'sd0, microword(0, 0, FN_ADD, 1, 1, 0, 0, EN_LV | EN_TOS, 0, 0, mdp_pkg::BSEL_LV),
        0, '0},
      '{0, 8'sd0, microword(0, 0, FN_AND, 1, 1, 1, 0, EN_CPP | EN_H, 0, 0,
                            mdp_pkg::BSEL_CPP), 0, '0},
      '{0, 8'sd0, microword(0, 0, FN_OR, 0, 1, 0, 0, EN_MDR | EN_PC, 0, 0,
                            mdp_pkg::BSEL_OPC), 0, '0},
      '{0, 8'sd0, microword(1, 0, FN_ADD, 1, 1, 0, 0, EN_TOS | EN_MDR, 0, 0,
                            mdp_pkg::BSEL_TOS), 0, '0},
      // read back word zero
      '{0, 8'sd0, microword(0, 0, FN_AND, 0, 0, 0, 0, EN_H | EN_MAR, 0, 1, mdp_pkg::BSEL_MDR),
        0, '0}
    };

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Walk the directed table
    foreach (plan[i]) begin
      if (plan[i].set_mbr) write_mbr(plan[i].mbr);
      send_word(plan[i].word, plan[i].typed, plan[i].want);
    end

    // Random phases, one instruction byte each; phase two runs without idling
    phase_mbr = '{8'sd127, -8'sd128, -8'sd1, 8'($urandom_range(255)), 8'sd0};
    for (int p = 0; p < 5; p++) begin
      write_mbr(phase_mbr[p]);
      calm = (p == 2);
      phase_end = words_sent + PHASE_WORDS;
      while (words_sent < phase_end) begin
        pick = $urandom_range(99);
        if (pick < 50) run_walk();
        else if (pick < 85) send_word(random_word(1'b1), 1'b0, '0);
        else send_word(random_word(1'b0), 1'b0, '0);
      end
    end
    calm = 1'b0;

    // Drain and let the pipeline settle
    uop_ch.valid <= 1'b0;
    @(posedge clk);
    while (pend_q.size() != 0 || want_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[files.f]
sv/mdp_pkg.sv
sv/mdp_if.sv
sv/mdp_alu.sv
sv/mdp_mem.sv
sv/microcoded_datapath_step.sv
dv/tb_top.sv
